// File: sv/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// shared types and constants of the lru page replacement block: defaults,
// controller states and the control groups passed along the frame chain
// ----------------------------------------------------------------------------
package lrupr_pkg;

   localparam int FRAMES_DEFAULT    = 16;
   localparam int PAGE_BITS_DEFAULT = 16;

   // fixed field widths of the request and response transactions
   localparam int PAGE_FIELD_W  = 16;
   localparam int INDEX_FIELD_W = 4;
   localparam int TOTAL_FIELD_W = 32;
   localparam int CSR_W         = 5;
   localparam int REQ_DATA_W    = 16;
   localparam int RSP_DATA_W    = 56;

   localparam logic [CSR_W-1:0]         CSR_RESET = 5'd16;
   localparam logic [TOTAL_FIELD_W-1:0] FAULT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // running search result handed from one frame cell to the next
   typedef struct packed {
      logic hit;     // an active frame holds the page
      logic empty;   // an active frame is empty
      logic any;     // an active frame has been seen (lru candidate set)
   } chain_flags_type;

   // update command broadcast to all cells at the end of a search
   typedef struct packed {
      logic strobe;  // apply the update this cycle
      logic load;    // write the page into the target frame (fault)
      logic age_all; // age every valid frame (fill of an empty frame)
   } upd_ctrl_type;

endpackage

// File: sv/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// lru page replacement over a chain of frame cells with a search record
// passed one cell per cycle and a broadcast rank update
// ----------------------------------------------------------------------------
// Each request transaction carries one page reference. The page is captured
// at the accepting edge and then searched through a chain of FRAMES cells,
// one cell per cycle. The search record ripples down the chain, and a
// final step then updates all frames and loads the response register. The
// request side is ready again in the cycle after that update, so a new
// reference is accepted only once the previous one has finished its search
// and update. A new request is accepted even while the previous response
// still waits to be taken; its update then waits until that response is
// taken. Response tdata bits: [0] page_fault, [4:1] frame_index,
// [5] evicted_valid, [21:6] evicted_page, [53:22] fault_total, rest zero.
// frames_in_use (csr_wdata) selects frames 0..n-1; 0 acts as 1 and values
// above FRAMES act as FRAMES. Reset empties every frame.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
   parameter int FRAMES    = lrupr_pkg::FRAMES_DEFAULT,
   parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lrupr_pkg::REQ_DATA_W-1:0]    req_tdata,   // [15:0] page_number
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] page_fault, [4:1] frame_index, [5] evicted_valid, [21:6] evicted_page,
   // [53:22] fault_total, [55:54] zero
   output logic [lrupr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [lrupr_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(FRAMES + 1);
   localparam int CW     = (CNT_W > lrupr_pkg::CSR_W) ? CNT_W : lrupr_pkg::CSR_W;
   localparam int PF_W   = lrupr_pkg::PAGE_FIELD_W;
   localparam int IF_W   = lrupr_pkg::INDEX_FIELD_W;
   localparam int TF_W   = lrupr_pkg::TOTAL_FIELD_W;

   lrupr_pkg::state_type          state_ff, state_in;
   logic [IDX_W-1:0]              cnt_ff, cnt_in;
   logic [lrupr_pkg::CSR_W-1:0]   csr_ff;
   logic [PAGE_BITS-1:0]          page_ff;
   logic [TF_W-1:0]               fault_cnt_ff, fault_cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lrupr_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CW-1:0]                 csr_w, n_active;
   logic [FRAMES-1:0]             frame_active;
   logic                          req_fire, done_fire;
   logic [PAGE_BITS+PF_W-1:0]     page_ext;

   lrupr_pkg::chain_flags_type    c_flags    [FRAMES+1];
   logic [IDX_W-1:0]              c_hit_idx  [FRAMES+1];
   logic [RANK_W-1:0]             c_hit_rank [FRAMES+1];
   logic [IDX_W-1:0]              c_empty_idx[FRAMES+1];
   logic [RANK_W-1:0]             c_lru_rank [FRAMES+1];
   logic [IDX_W-1:0]              c_lru_idx  [FRAMES+1];
   logic [PAGE_BITS-1:0]          c_lru_page [FRAMES+1];

   lrupr_pkg::upd_ctrl_type       upd;
   logic [IDX_W-1:0]              upd_target;
   logic [RANK_W-1:0]             upd_limit;
   logic                          ev_valid;
   logic [PAGE_BITS-1:0]          ev_page;
   logic [PAGE_BITS+PF_W-1:0]     ev_page_ext;
   logic [IDX_W+IF_W-1:0]         target_ext;

   // active frame count, clamped to 1..FRAMES
   assign csr_w = CW'(csr_ff);
   always_comb begin
      priority if (csr_w == '0) begin
         n_active = CW'(1);
      end else if (csr_w > CW'(FRAMES)) begin
         n_active = CW'(FRAMES);
      end else begin
         n_active = csr_w;
      end
   end

   assign page_ext = {{PAGE_BITS{1'b0}}, req_tdata[PF_W-1:0]};

   assign req_tready = (state_ff == lrupr_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign done_fire  = (state_ff == lrupr_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // chain head: empty search record
   assign c_flags[0]     = '0;
   assign c_hit_idx[0]   = '0;
   assign c_hit_rank[0]  = '0;
   assign c_empty_idx[0] = '0;
   assign c_lru_rank[0]  = '0;
   assign c_lru_idx[0]   = '0;
   assign c_lru_page[0]  = '0;

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      assign frame_active[i] = (CW'(i) < n_active);

      lrupr_cell #(
         .IDX       (i),
         .IDX_W     (IDX_W),
         .RANK_W    (RANK_W),
         .PAGE_BITS (PAGE_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .active        (frame_active[i]),
         .page          (page_ff),
         .upd           (upd),
         .upd_target    (upd_target),
         .upd_limit     (upd_limit),
         .in_flags      (c_flags[i]),
         .in_hit_idx    (c_hit_idx[i]),
         .in_hit_rank   (c_hit_rank[i]),
         .in_empty_idx  (c_empty_idx[i]),
         .in_lru_rank   (c_lru_rank[i]),
         .in_lru_idx    (c_lru_idx[i]),
         .in_lru_page   (c_lru_page[i]),
         .out_flags     (c_flags[i+1]),
         .out_hit_idx   (c_hit_idx[i+1]),
         .out_hit_rank  (c_hit_rank[i+1]),
         .out_empty_idx (c_empty_idx[i+1]),
         .out_lru_rank  (c_lru_rank[i+1]),
         .out_lru_idx   (c_lru_idx[i+1]),
         .out_lru_page  (c_lru_page[i+1])
      );
   end

   // decision from the record at the chain tail
   always_comb begin
      upd.strobe  = done_fire;
      upd.load    = !c_flags[FRAMES].hit;
      upd.age_all = !c_flags[FRAMES].hit && c_flags[FRAMES].empty;
      priority if (c_flags[FRAMES].hit) begin
         upd_target = c_hit_idx[FRAMES];
         upd_limit  = c_hit_rank[FRAMES];
      end else if (c_flags[FRAMES].empty) begin
         upd_target = c_empty_idx[FRAMES];
         upd_limit  = c_lru_rank[FRAMES];
      end else begin
         upd_target = c_lru_idx[FRAMES];
         upd_limit  = c_lru_rank[FRAMES];
      end
      ev_valid = !c_flags[FRAMES].hit && !c_flags[FRAMES].empty;
      ev_page  = ev_valid ? c_lru_page[FRAMES] : '0;
   end

   assign ev_page_ext = {{PF_W{1'b0}}, ev_page};
   assign target_ext  = {{IF_W{1'b0}}, upd_target};

   always_comb begin
      fault_cnt_in = fault_cnt_ff;
      if (done_fire && upd.load && (fault_cnt_ff != lrupr_pkg::FAULT_MAX)) begin
         fault_cnt_in = fault_cnt_ff + TF_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, fault_cnt_in, ev_page_ext[PF_W-1:0], ev_valid,
                         target_ext[IF_W-1:0], upd.load};
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         lrupr_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = lrupr_pkg::ST_SCAN;
               cnt_in   = '0;
            end
         end
         lrupr_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_ff == IDX_W'(FRAMES - 1)) begin
               state_in = lrupr_pkg::ST_DONE;
            end
         end
         lrupr_pkg::ST_DONE: begin
            if (done_fire) begin
               state_in = lrupr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lrupr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrupr_pkg::ST_IDLE;
         cnt_ff       <= '0;
         csr_ff       <= lrupr_pkg::CSR_RESET;
         fault_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fault_cnt_ff <= fault_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         page_ff <= page_ext[PAGE_BITS-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: sv/lrupr_cell.sv
// ----------------------------------------------------------------------------
// lrupr_cell
// one frame of the replacement chain: holds valid, page and recency rank,
// merges its own frame into the search record from its left neighbor and
// registers the record for its right neighbor
// ----------------------------------------------------------------------------
module lrupr_cell #(
   parameter int IDX       = 0,
   parameter int IDX_W     = 4,
   parameter int RANK_W    = 4,
   parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          active,
   input  logic [PAGE_BITS-1:0]          page,
   input  lrupr_pkg::upd_ctrl_type       upd,
   input  logic [IDX_W-1:0]              upd_target,
   input  logic [RANK_W-1:0]             upd_limit,
   input  lrupr_pkg::chain_flags_type    in_flags,
   input  logic [IDX_W-1:0]              in_hit_idx,
   input  logic [RANK_W-1:0]             in_hit_rank,
   input  logic [IDX_W-1:0]              in_empty_idx,
   input  logic [RANK_W-1:0]             in_lru_rank,
   input  logic [IDX_W-1:0]              in_lru_idx,
   input  logic [PAGE_BITS-1:0]          in_lru_page,
   output lrupr_pkg::chain_flags_type    out_flags,
   output logic [IDX_W-1:0]              out_hit_idx,
   output logic [RANK_W-1:0]             out_hit_rank,
   output logic [IDX_W-1:0]              out_empty_idx,
   output logic [RANK_W-1:0]             out_lru_rank,
   output logic [IDX_W-1:0]              out_lru_idx,
   output logic [PAGE_BITS-1:0]          out_lru_page
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic                       valid_ff, valid_in;
   logic [PAGE_BITS-1:0]       page_ff, page_in;
   logic [RANK_W-1:0]          rank_ff, rank_in;

   lrupr_pkg::chain_flags_type flags_ff, flags_in;
   logic [IDX_W-1:0]           hit_idx_ff, hit_idx_in;
   logic [RANK_W-1:0]          hit_rank_ff, hit_rank_in;
   logic [IDX_W-1:0]           empty_idx_ff, empty_idx_in;
   logic [RANK_W-1:0]          lru_rank_ff, lru_rank_in;
   logic [IDX_W-1:0]           lru_idx_ff, lru_idx_in;
   logic [PAGE_BITS-1:0]       lru_page_ff, lru_page_in;

   logic                       own_hit;

   assign own_hit = active && valid_ff && (page_ff == page);

   // merge this frame into the search record, lowest index wins
   always_comb begin
      flags_in     = in_flags;
      hit_idx_in   = in_hit_idx;
      hit_rank_in  = in_hit_rank;
      empty_idx_in = in_empty_idx;
      lru_rank_in  = in_lru_rank;
      lru_idx_in   = in_lru_idx;
      lru_page_in  = in_lru_page;
      if (!in_flags.hit && own_hit) begin
         flags_in.hit = 1'b1;
         hit_idx_in   = MY_IDX;
         hit_rank_in  = rank_ff;
      end
      if (!in_flags.empty && active && !valid_ff) begin
         flags_in.empty = 1'b1;
         empty_idx_in   = MY_IDX;
      end
      // strictly older replaces, so ties keep the lower index
      if (active && (!in_flags.any || (rank_ff > in_lru_rank))) begin
         lru_rank_in = rank_ff;
         lru_idx_in  = MY_IDX;
         lru_page_in = page_ff;
      end
      flags_in.any = in_flags.any || active;
   end

   always_comb begin
      valid_in = valid_ff;
      page_in  = page_ff;
      rank_in  = rank_ff;
      if (upd.strobe) begin
         if (upd_target == MY_IDX) begin
            valid_in = 1'b1;
            rank_in  = '0;
            if (upd.load) begin
               page_in = page;
            end
         end else if (valid_ff && (upd.age_all || (rank_ff < upd_limit))) begin
            rank_in = rank_ff + RANK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         page_ff  <= '0;
         rank_ff  <= '0;
         flags_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         page_ff  <= page_in;
         rank_ff  <= rank_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      hit_rank_ff  <= hit_rank_in;
      empty_idx_ff <= empty_idx_in;
      lru_rank_ff  <= lru_rank_in;
      lru_idx_ff   <= lru_idx_in;
      lru_page_ff  <= lru_page_in;
   end

   assign out_flags     = flags_ff;
   assign out_hit_idx   = hit_idx_ff;
   assign out_hit_rank  = hit_rank_ff;
   assign out_empty_idx = empty_idx_ff;
   assign out_lru_rank  = lru_rank_ff;
   assign out_lru_idx   = lru_idx_ff;
   assign out_lru_page  = lru_page_ff;

endmodule
